### sv/imab_pkg.sv
// ----------------------------------------------------------------------------
// imab_pkg
// Shared types, constants and the IMA step arithmetic for the block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imab_pkg;

  localparam int unsigned STEP_TABLE_SIZE = 89;
  localparam logic [6:0]  MAX_STEP_POS    = 7'(STEP_TABLE_SIZE - 1);
  localparam logic [15:0] OFFSET_ZERO     = 16'h8000;
  localparam logic [15:0] SAMPLE_MAX      = 16'hFFFF;
  localparam logic [15:0] BLOCK_BYTES_RST = 16'd256;
  localparam logic [23:0] MIN_BLOCK_BYTES = 24'd4;

  // Register indexes on the configuration port.
  localparam logic CFG_BLOCK_BYTES  = 1'b0;
  localparam logic CFG_STREAM_BYTES = 1'b1;

  // Role of one accepted byte inside its block.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_HDR_LO,
    KIND_HDR_HI,
    KIND_HDR_STEP,
    KIND_DATA
  } kind_t;

  // Byte handed from the framer to the decoder.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] code_byte;
  } item_t;

  // Result of one nibble step.
  typedef struct packed {
    logic [15:0] predictor;
    logic [6:0]  step_pos;
  } step_res_t;

  // IMA step size table.
  function automatic logic [14:0] step_size(input logic [6:0] pos);
    logic [14:0] s;
    case (pos)
      7'd0: s = 15'd7;         7'd1: s = 15'd8;         7'd2: s = 15'd9;
      7'd3: s = 15'd10;        7'd4: s = 15'd11;        7'd5: s = 15'd12;
      7'd6: s = 15'd13;        7'd7: s = 15'd14;        7'd8: s = 15'd16;
      7'd9: s = 15'd17;        7'd10: s = 15'd19;       7'd11: s = 15'd21;
      7'd12: s = 15'd23;       7'd13: s = 15'd25;       7'd14: s = 15'd28;
      7'd15: s = 15'd31;       7'd16: s = 15'd34;       7'd17: s = 15'd37;
      7'd18: s = 15'd41;       7'd19: s = 15'd45;       7'd20: s = 15'd50;
      7'd21: s = 15'd55;       7'd22: s = 15'd60;       7'd23: s = 15'd66;
      7'd24: s = 15'd73;       7'd25: s = 15'd80;       7'd26: s = 15'd88;
      7'd27: s = 15'd97;       7'd28: s = 15'd107;      7'd29: s = 15'd118;
      7'd30: s = 15'd130;      7'd31: s = 15'd143;      7'd32: s = 15'd157;
      7'd33: s = 15'd173;      7'd34: s = 15'd190;      7'd35: s = 15'd209;
      7'd36: s = 15'd230;      7'd37: s = 15'd253;      7'd38: s = 15'd279;
      7'd39: s = 15'd307;      7'd40: s = 15'd337;      7'd41: s = 15'd371;
      7'd42: s = 15'd408;      7'd43: s = 15'd449;      7'd44: s = 15'd494;
      7'd45: s = 15'd544;      7'd46: s = 15'd598;      7'd47: s = 15'd658;
      7'd48: s = 15'd724;      7'd49: s = 15'd796;      7'd50: s = 15'd876;
      7'd51: s = 15'd963;      7'd52: s = 15'd1060;     7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;     7'd55: s = 15'd1411;     7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;     7'd58: s = 15'd1878;     7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;     7'd61: s = 15'd2499;     7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;     7'd64: s = 15'd3327;     7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;     7'd67: s = 15'd4428;     7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;     7'd70: s = 15'd5894;     7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;     7'd73: s = 15'd7845;     7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;     7'd76: s = 15'd10442;    7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;    7'd79: s = 15'd13899;    7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;    7'd82: s = 15'd18500;    7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;    7'd85: s = 15'd24623;    7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // One IMA nibble: predictor update with clamping, then step position update.
  function automatic step_res_t nibble_step(input logic [15:0] pred,
                                            input logic [6:0]  pos,
                                            input logic [3:0]  code);
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] nxt;
    logic signed [8:0]  npos;
    step_res_t          r;
    step = step_size(pos);
    diff = 17'(step >> 3);
    if (code[2]) diff = diff + 17'(step);
    if (code[1]) diff = diff + 17'(step >> 1);
    if (code[0]) diff = diff + 17'(step >> 2);
    if (code[3]) nxt = $signed({2'b00, pred}) - $signed({1'b0, diff});
    else         nxt = $signed({2'b00, pred}) + $signed({1'b0, diff});
    if (nxt < 0)                                r.predictor = '0;
    else if (nxt > $signed({2'b00, SAMPLE_MAX})) r.predictor = SAMPLE_MAX;
    else                                        r.predictor = nxt[15:0];
    // Small codes step down by one, large codes step up by 2, 4, 6 or 8.
    if (code[2]) npos = $signed({2'b00, pos}) + $signed({6'd0, code[1:0], 1'b0} + 9'sd2);
    else         npos = $signed({2'b00, pos}) - 9'sd1;
    if (npos < 0)                                  r.step_pos = '0;
    else if (npos > $signed({2'b00, MAX_STEP_POS})) r.step_pos = MAX_STEP_POS;
    else                                           r.step_pos = npos[6:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/imab_framer.sv
// ----------------------------------------------------------------------------
// imab_framer
// Tracks stream and block boundaries, classifies each accepted byte and
// holds it in the item register for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module imab_framer
  import imab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // [7:0] code_byte
  input  wire logic        s_tuser,     // [0] new_stream
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  output logic             item_valid,
  output item_t            item,
  input  wire logic        item_take
);

  logic [15:0] block_bytes;
  logic [23:0] stream_bytes;
  logic [23:0] bytes_left;
  logic [15:0] byte_in_block;
  logic [15:0] cur_len;
  logic        block_skipped;

  logic [23:0] bl;
  logic [15:0] bib;
  logic [15:0] cbl;
  logic        skip;
  logic [23:0] len;
  logic        opens;
  logic        too_short;
  logic        dropped;
  logic [15:0] pos;
  kind_t       kind;
  logic        in_accept;

  assign s_tready  = !item_valid || item_take;
  assign in_accept = s_tvalid && s_tready;

  // Counters as seen by this byte, after an optional stream reload.
  always_comb begin
    bl   = bytes_left;
    bib  = byte_in_block;
    cbl  = cur_len;
    skip = block_skipped;
    if (s_tuser) begin
      bl   = stream_bytes;
      bib  = '0;
      cbl  = '0;
      skip = 1'b0;
    end
    len       = ({8'd0, block_bytes} > bl) ? bl : {8'd0, block_bytes};
    opens     = bib >= cbl;
    too_short = len < MIN_BLOCK_BYTES;
    dropped   = skip || (opens && too_short);
    pos       = opens ? '0 : bib;
    if (dropped)           kind = KIND_NONE;
    else if (pos == 16'd0) kind = KIND_HDR_LO;
    else if (pos == 16'd1) kind = KIND_HDR_HI;
    else if (pos == 16'd2) kind = KIND_HDR_STEP;
    else                   kind = KIND_DATA;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes  <= BLOCK_BYTES_RST;
      stream_bytes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES:  block_bytes  <= cfg_data[15:0];
        CFG_STREAM_BYTES: stream_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block bookkeeping, updated once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      byte_in_block <= '0;
      cur_len       <= '0;
      block_skipped <= 1'b0;
    end else if (in_accept) begin
      block_skipped <= dropped;
      if (dropped) begin
        bytes_left    <= bl;
        byte_in_block <= bib;
        cur_len       <= cbl;
      end else begin
        bytes_left    <= opens ? bl - len : bl;
        cur_len       <= opens ? len[15:0] : cbl;
        byte_in_block <= pos + 16'd1;
      end
    end
  end

  // Item register; bytes that give nothing are not passed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= kind != KIND_NONE;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item.kind      <= kind;
      item.code_byte <= s_tdata;
    end
  end

endmodule

`default_nettype wire

### sv/imab_decoder.sv
// ----------------------------------------------------------------------------
// imab_decoder
// Applies header bytes to the predictor state and runs one IMA nibble step
// per cycle into the result register while that register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module imab_decoder
  import imab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire item_t       item,
  output logic             item_take,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,     // [15:0] sample
  output logic             m_tuser,     // [0] is_header_sample
  output logic             m_tlast      // [0] last
);

  logic [15:0] predictor;
  logic [6:0]  step_pos;
  logic [7:0]  low_hdr;
  logic        phase;

  logic        out_free;
  logic        emit;
  logic [3:0]  code;
  step_res_t   res;
  logic [6:0]  hdr_pos;

  assign out_free = !m_tvalid || m_tready;
  assign code     = phase ? item.code_byte[7:4] : item.code_byte[3:0];
  assign res      = nibble_step(predictor, step_pos, code);
  assign hdr_pos  = (item.code_byte > 8'(MAX_STEP_POS)) ? MAX_STEP_POS : item.code_byte[6:0];

  // Header bytes that give no result move on at once; the rest wait for room.
  always_comb begin
    item_take = 1'b0;
    emit      = 1'b0;
    if (item_valid) begin
      unique case (item.kind) inside
        KIND_HDR_LO, KIND_HDR_HI: item_take = 1'b1;
        KIND_HDR_STEP: begin
          item_take = out_free;
          emit      = out_free;
        end
        KIND_DATA: begin
          item_take = out_free && phase;
          emit      = out_free;
        end
        default: item_take = 1'b1;
      endcase
    end
  end

  // Decoder state: predictor, step position, header low byte, nibble phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor <= '0;
      step_pos  <= '0;
      low_hdr   <= '0;
      phase     <= 1'b0;
    end else if (item_valid) begin
      unique case (item.kind)
        KIND_HDR_LO: low_hdr <= item.code_byte;
        KIND_HDR_HI: predictor <= {item.code_byte, low_hdr} ^ OFFSET_ZERO;
        KIND_HDR_STEP: begin
          if (out_free) step_pos <= hdr_pos;
        end
        KIND_DATA: begin
          if (out_free) begin
            predictor <= res.predictor;
            step_pos  <= res.step_pos;
            phase     <= !phase;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (item.kind == KIND_HDR_STEP) begin
        m_tdata <= predictor;
        m_tuser <= 1'b1;
        m_tlast <= 1'b1;
      end else begin
        m_tdata <= res.predictor;
        m_tuser <= 1'b0;
        m_tlast <= phase;
      end
    end
  end

endmodule

`default_nettype wire

### sv/ima_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// ima_adpcm_block_decoder
// Block-structured mono IMA ADPCM decoder, 4-bit codes, 16-bit offset-binary
// samples.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Contents
//  s_*      s_tvalid s_tready s_tdata s_tuser code_byte, new_stream
//  m_*      m_tvalid m_tready m_tdata m_tuser sample, is_header_sample,
//           m_tlast                          last
//  cfg_*    cfg_we cfg_index cfg_data         0 block_bytes, 1 stream_bytes
//
//  An accepted byte is held in the framer's item register; its result is then
//  registered in the output register.
//  A data byte gives one sample per nibble through the single nibble step
//  unit and holds the item register until its second nibble is taken. Bytes
//  of a skipped block are dropped at the input and never reach the decoder.
//  rst is synchronous and active high; it clears all counters and the state.
//  A stalled output holds its result; the item register still takes bytes
//  until it holds one that needs room in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_block_decoder
  import imab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // [7:0] code_byte
  input  wire logic        s_tuser,     // [0] new_stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,     // [15:0] sample
  output logic             m_tuser,     // [0] is_header_sample
  output logic             m_tlast,     // last
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic  item_valid;
  item_t item;
  logic  item_take;

  imab_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  imab_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

### sv/imab_checker.sv
// ----------------------------------------------------------------------------
// imab_checker
// Port-level checks on the block decoder's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module imab_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // A header sample is the only result of its byte.
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("header sample without last");

  // The second nibble of a data byte follows right after the first is taken.
  a_second_nibble: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser && m_tlast)
    else $error("second sample of a data byte missing");

endmodule

bind ima_adpcm_block_decoder imab_checker u_imab_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
